@@ design/nga_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nga_pkg
// Shared types, constants and fixed-point helpers of the natural-gradient
// Adam update core.
// ----------------------------------------------------------------------------
package nga_pkg;

  localparam int VALUE_W    = 32;
  localparam int STEP_W     = 16;
  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 24;

  // valid-line taps of the pipeline stages
  localparam int ST_N       = 3 + DIV_STEPS;
  localparam int ST_M2      = ST_N + 3;
  localparam int ST_MH      = ST_N + 4 + DIV_STEPS;
  localparam int ST_DEN     = ST_MH + SQRT_STEPS + 2;
  localparam int ST_UPD     = ST_DEN + DIV_STEPS + 1;
  localparam int PIPE_DEPTH = ST_UPD + 2;
  // sideband slot that feeds the bias-correction power chains
  localparam int POW_TAP    = DIV_STEPS - STEP_W + 2;

  typedef logic [VALUE_W-1:0] val_t;

  localparam val_t UMAXV = 32'hFFFF_FFFF;
  localparam val_t SMAXV = 32'h7FFF_FFFF;
  localparam val_t SNEGV = 32'h8000_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    CFG_LEARN_RATE    = 3'd0,
    CFG_MOMENT_DECAY  = 3'd1,
    CFG_SQUARE_DECAY  = 3'd2,
    CFG_FISHER_DECAY  = 3'd3,
    CFG_FISHER_OFFSET = 3'd4,
    CFG_DENOM_FLOOR   = 3'd5,
    CFG_DECAY_RATE    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic neg;
    val_t mag;
  } smag_t;

  typedef struct packed {
    logic        neg;
    logic [32:0] mag;
  } wsmag_t;

  // one restoring-division step: remainder, dividend bits still to come
  typedef struct packed {
    logic        ovf;
    logic [32:0] rem;
    logic [31:0] low;
    logic [32:0] den;
    logic [31:0] quo;
  } div_t;

  // square and multiply step of beta^t in Q1.32
  typedef struct packed {
    logic [32:0]       p;
    logic [32:0]       base;
    logic [STEP_W-1:0] t;
  } pow_t;

  // one digit of the integer square root
  typedef struct packed {
    logic [25:0] rem;
    logic [47:0] xl;
    logic [23:0] root;
  } sqrt_t;

  typedef struct packed {
    logic  gneg;
    smag_t w1;
    smag_t m0;
    val_t  v0;
    val_t  f;
    logic [STEP_W-1:0] t;
  } side1_t;

  typedef struct packed {
    val_t  f;
    smag_t m;
    val_t  v;
    smag_t w1;
  } side_t;

  typedef struct packed {
    val_t  f;
    smag_t m;
    val_t  v;
    smag_t w1;
    val_t  mh;
  } side3_t;

  function automatic div_t div_init(input logic [63:0] num, input logic [32:0] den);
    div_t c;
    logic ovf;
    ovf   = {1'b0, num[63:32]} >= den;
    c.ovf = ovf;
    c.rem = ovf ? 33'd0 : {1'b0, num[63:32]};
    c.low = num[31:0];
    c.den = den;
    c.quo = '0;
    return c;
  endfunction

  // product >> 16, rounded half up, capped
  function automatic val_t rnd_q16(input logic [63:0] p);
    logic [64:0] s;
    s = {1'b0, p} + 65'd32768;
    return (|s[64:48]) ? UMAXV : s[47:16];
  endfunction

  function automatic val_t rnd_q24(input logic [55:0] p);
    logic [56:0] s;
    s = {1'b0, p} + 57'h80_0000;
    return (|s[56:56]) ? UMAXV : s[55:24];
  endfunction

  function automatic val_t rnd_q40(input logic [72:0] p);
    logic [73:0] s;
    s = {1'b0, p} + (74'd1 << 39);
    return (|s[73:72]) ? UMAXV : s[71:40];
  endfunction

  function automatic logic [32:0] rnd_q32_cap(input logic [65:0] p);
    logic [66:0] s;
    logic [34:0] r;
    s = {1'b0, p} + (67'd1 << 31);
    r = s[66:32];
    return (r > {2'b0, ONE_Q32}) ? ONE_Q32 : r[32:0];
  endfunction

  function automatic smag_t from_bits(input val_t x);
    smag_t s;
    s.neg = x[VALUE_W-1];
    s.mag = s.neg ? (~x + 32'd1) : x;
    return s;
  endfunction

  function automatic val_t to_bits(input smag_t s);
    return s.neg ? (~s.mag + 32'd1) : s.mag;
  endfunction

  function automatic wsmag_t sm_add(input smag_t a, input smag_t b);
    wsmag_t s;
    if (a.neg == b.neg) begin
      s.neg = a.neg;
      s.mag = {1'b0, a.mag} + {1'b0, b.mag};
    end else if (a.mag >= b.mag) begin
      s.neg = a.neg;
      s.mag = {1'b0, a.mag - b.mag};
    end else begin
      s.neg = b.neg;
      s.mag = {1'b0, b.mag - a.mag};
    end
    if (s.mag == '0) s.neg = 1'b0;
    return s;
  endfunction

  function automatic smag_t clamp_s(input wsmag_t s);
    smag_t c;
    c.neg = s.neg;
    if (s.neg && s.mag > {1'b0, SNEGV}) c.mag = SNEGV;
    else if (!s.neg && s.mag > {1'b0, SMAXV}) c.mag = SMAXV;
    else c.mag = s.mag[31:0];
    if (c.mag == '0) c.neg = 1'b0;
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/nga_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nga_div_cell
// One stage of the restoring divider: brings down one dividend bit and
// emits one quotient bit.
// ----------------------------------------------------------------------------
module nga_div_cell (
  input  wire logic          clk,
  input  nga_pkg::div_t      cell_in,
  output nga_pkg::div_t      cell_out
);
  import nga_pkg::*;

  logic [33:0] shifted;
  logic        ge;
  div_t        cell_nxt;
  div_t        cell_r;

  always_comb begin
    shifted  = {cell_in.rem, cell_in.low[31]};
    ge       = shifted >= {1'b0, cell_in.den};
    cell_nxt = cell_in;
    cell_nxt.low = {cell_in.low[30:0], 1'b0};
    cell_nxt.quo = {cell_in.quo[30:0], ge};
    if (ge) begin
      cell_nxt.rem = 33'(shifted - {1'b0, cell_in.den});
    end else begin
      cell_nxt.rem = shifted[32:0];
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

@@ design/nga_pow_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nga_pow_cell
// One square-and-multiply step of beta^t, handling one bit of the step count.
// ----------------------------------------------------------------------------
module nga_pow_cell (
  input  wire logic     clk,
  input  nga_pkg::pow_t cell_in,
  output nga_pkg::pow_t cell_out
);
  import nga_pkg::*;

  pow_t cell_nxt;
  pow_t cell_r;

  always_comb begin
    cell_nxt.p    = cell_in.t[0] ? rnd_q32_cap(66'(cell_in.p) * 66'(cell_in.base))
                                 : cell_in.p;
    cell_nxt.base = rnd_q32_cap(66'(cell_in.base) * 66'(cell_in.base));
    cell_nxt.t    = {1'b0, cell_in.t[STEP_W-1:1]};
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

@@ design/nga_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nga_sqrt_cell
// One digit step of the integer square root: two radicand bits in, one root
// bit out.
// ----------------------------------------------------------------------------
module nga_sqrt_cell (
  input  wire logic      clk,
  input  nga_pkg::sqrt_t cell_in,
  output nga_pkg::sqrt_t cell_out
);
  import nga_pkg::*;

  logic [27:0] r4;
  logic [25:0] trial;
  logic        ge;
  sqrt_t       cell_nxt;
  sqrt_t       cell_r;

  always_comb begin
    r4    = {cell_in.rem, cell_in.xl[47:46]};
    trial = {cell_in.root, 2'b01};
    ge    = r4 >= {2'b00, trial};
    cell_nxt.xl   = {cell_in.xl[45:0], 2'b00};
    cell_nxt.root = {cell_in.root[22:0], ge};
    if (ge) begin
      cell_nxt.rem = 26'(r4 - {2'b00, trial});
    end else begin
      cell_nxt.rem = r4[25:0];
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

@@ design/natural_gradient_adam_update_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// natural_gradient_adam_update_core
// Natural-gradient Adam update of one Q16.16 weight element per transfer.
// ----------------------------------------------------------------------------
// One element is taken in every clock cycle; busy stays low. Each result
// appears on the out_ ports for one cycle with out_valid high, in order.
// The pipeline runs through four 32-cell restoring divider chains (natural
// gradient, two for the bias-corrected moments, Adam step) and a 24-cell
// square-root chain; the bias-correction powers run in two 16-cell chains
// alongside the first divider. Results cannot be held off. Configuration
// writes are registered and should be made with the pipeline empty.
module natural_gradient_adam_update_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_gradient,
  input  wire logic signed [31:0] in_weight_in,
  input  wire logic        [31:0] in_fisher_in,
  input  wire logic signed [31:0] in_first_moment_in,
  input  wire logic        [31:0] in_second_moment_in,
  input  wire logic        [15:0] in_step_count,
  output logic                    out_valid,
  output logic signed [31:0]      out_weight_out,
  output logic        [31:0]      out_fisher_out,
  output logic signed [31:0]      out_first_moment_out,
  output logic        [31:0]      out_second_moment_out,
  input  wire logic               cfg_we,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [23:0] cfg_data
);
  import nga_pkg::*;

  // configuration
  logic [23:0] lr_r;
  logic [15:0] b1_r, b2_r, bf_r, off_r, eps_r, wd_r;
  logic [39:0] lrwd_r;
  logic [16:0] omb1, omb2, ombf;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  accept;

  // S1 / S2 / S3
  smag_t g_in;
  smag_t g_r, w_r, m0_r, g2_r, w2_r, m02_r;
  val_t  f0_r, v0_r, gsq_r, v02_r;
  logic [STEP_W-1:0] t_r, t2_r;
  val_t  fa_r, fb_r;
  logic [51:0] decl_r, dech_r;
  val_t  f_s3;
  logic [32:0] d_s3;
  val_t  dec_s3;
  smag_t w1_s3;
  div_t  div1_init_r;
  side1_t s3_side_r;
  side1_t side1_r [DIV_STEPS];

  // S4..S7
  smag_t n_r;
  val_t  n_cap, n_mag;
  side1_t s4_side_r;
  val_t  a_r, b_r, nsq_r, va_r;
  logic  m0neg5_r, nneg5_r;
  val_t  f5_r;
  smag_t w15_r;
  smag_t m6_r;
  val_t  vb_r, va6_r, f6_r;
  smag_t w16_r;
  val_t  v_s7;
  logic [32:0] bc1, bc2;
  div_t  div2a_init_r, div2b_init_r;
  side_t s7_side_r;
  side_t side2_r [DIV_STEPS];

  // S8..S12
  val_t  mh_cap, mh_s8, vh_s8;
  sqrt_t sqrt_init_r;
  side3_t s8_side_r;
  side3_t side3_r [SQRT_STEPS];
  val_t  x_r;
  logic [24:0] den_r;
  side_t s9_side_r;
  div_t  div3_init_r;
  side_t s10_side_r;
  side_t side4_r [DIV_STEPS];
  val_t  upd_r;
  side_t s11_side_r;
  smag_t upd_s;
  smag_t wn_s;
  val_t  wout_r, fout_r, mout_r, vout_r;

  // cell chains
  div_t  c1_q  [DIV_STEPS+1];
  div_t  c2a_q [DIV_STEPS+1];
  div_t  c2b_q [DIV_STEPS+1];
  div_t  c3_q  [DIV_STEPS+1];
  sqrt_t sq_q  [SQRT_STEPS+1];
  pow_t  p1_q  [STEP_W+1];
  pow_t  p2_q  [STEP_W+1];

  function automatic val_t rnd_sum(input val_t a, input val_t b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? UMAXV : s[31:0];
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign omb1 = 17'h1_0000 - {1'b0, b1_r};
  assign omb2 = 17'h1_0000 - {1'b0, b2_r};
  assign ombf = 17'h1_0000 - {1'b0, bf_r};

  assign g_in = from_bits(val_t'(in_gradient));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= 24'd16777;
      b1_r  <= 16'd58982;
      b2_r  <= 16'd65470;
      bf_r  <= 16'd62259;
      off_r <= 16'd66;
      eps_r <= 16'd1;
      wd_r  <= 16'd0;
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], accept};
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LEARN_RATE:    lr_r  <= cfg_data;
          CFG_MOMENT_DECAY:  b1_r  <= cfg_data[15:0];
          CFG_SQUARE_DECAY:  b2_r  <= cfg_data[15:0];
          CFG_FISHER_DECAY:  bf_r  <= cfg_data[15:0];
          CFG_FISHER_OFFSET: off_r <= cfg_data[15:0];
          CFG_DENOM_FLOOR:   eps_r <= cfg_data[15:0];
          CFG_DECAY_RATE:    wd_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // ---- combinational pieces of the stages ----
  always_comb begin
    f_s3   = rnd_sum(fa_r, fb_r);
    d_s3   = {1'b0, f_s3} + {17'b0, off_r};
    dec_s3 = rnd_q40(73'({dech_r, 20'b0}) + 73'(decl_r));
    w1_s3.mag = (dec_s3 > w2_r.mag) ? 32'd0 : (w2_r.mag - dec_s3);
    w1_s3.neg = w2_r.neg && (w1_s3.mag != '0);

    n_cap = side1_r[DIV_STEPS-1].gneg ? SNEGV : SMAXV;
    if (c1_q[DIV_STEPS].ovf || c1_q[DIV_STEPS].quo > n_cap) n_mag = n_cap;
    else n_mag = c1_q[DIV_STEPS].quo;

    v_s7 = rnd_sum(va6_r, vb_r);
    bc1  = ONE_Q32 - p1_q[STEP_W].p;
    bc2  = ONE_Q32 - p2_q[STEP_W].p;

    mh_cap = side2_r[DIV_STEPS-1].m.neg ? SNEGV : SMAXV;
    if (c2a_q[DIV_STEPS].ovf || c2a_q[DIV_STEPS].quo > mh_cap) mh_s8 = mh_cap;
    else mh_s8 = c2a_q[DIV_STEPS].quo;
    vh_s8 = c2b_q[DIV_STEPS].ovf ? UMAXV : c2b_q[DIV_STEPS].quo;

    upd_s.mag = upd_r;
    upd_s.neg = !s11_side_r.m.neg && (upd_r != '0);
    wn_s      = clamp_s(sm_add(s11_side_r.w1, upd_s));
  end

  // ---- pipeline payload ----
  always_ff @(posedge clk) begin
    lrwd_r <= 40'(lr_r) * 40'(wd_r);

    // S1
    g_r   <= from_bits(val_t'(in_gradient));
    w_r   <= from_bits(val_t'(in_weight_in));
    m0_r  <= from_bits(val_t'(in_first_moment_in));
    f0_r  <= in_fisher_in;
    v0_r  <= in_second_moment_in;
    t_r   <= (in_step_count == '0) ? STEP_W'(1) : in_step_count;
    gsq_r <= rnd_q16(64'(g_in.mag) * 64'(g_in.mag));

    // S2
    fa_r   <= rnd_q16(64'(f0_r) * 64'(bf_r));
    fb_r   <= rnd_q16(64'(gsq_r) * 64'(ombf));
    decl_r <= 52'(w_r.mag) * 52'(lrwd_r[19:0]);
    dech_r <= 52'(w_r.mag) * 52'(lrwd_r[39:20]);
    g2_r   <= g_r;
    w2_r   <= w_r;
    m02_r  <= m0_r;
    v02_r  <= v0_r;
    t2_r   <= t_r;

    // S3: natural gradient division set up; zero gradient divides 0 by 1
    div1_init_r <= (g2_r.mag == '0) ? div_init(64'd0, 33'd1)
                                    : div_init({16'b0, g2_r.mag, 16'b0}, d_s3);
    s3_side_r.gneg <= g2_r.neg;
    s3_side_r.w1   <= w1_s3;
    s3_side_r.m0   <= m02_r;
    s3_side_r.v0   <= v02_r;
    s3_side_r.f    <= f_s3;
    s3_side_r.t    <= t2_r;

    side1_r[0] <= s3_side_r;
    for (int k = 1; k < DIV_STEPS; k++) side1_r[k] <= side1_r[k-1];

    // S4
    n_r.mag   <= n_mag;
    n_r.neg   <= side1_r[DIV_STEPS-1].gneg && (n_mag != '0);
    s4_side_r <= side1_r[DIV_STEPS-1];

    // S5
    a_r      <= rnd_q16(64'(s4_side_r.m0.mag) * 64'(b1_r));
    b_r      <= rnd_q16(64'(n_r.mag) * 64'(omb1));
    nsq_r    <= rnd_q16(64'(n_r.mag) * 64'(n_r.mag));
    va_r     <= rnd_q16(64'(s4_side_r.v0) * 64'(b2_r));
    m0neg5_r <= s4_side_r.m0.neg;
    nneg5_r  <= n_r.neg;
    f5_r     <= s4_side_r.f;
    w15_r    <= s4_side_r.w1;

    // S6
    m6_r  <= clamp_s(sm_add('{neg: m0neg5_r, mag: a_r}, '{neg: nneg5_r, mag: b_r}));
    vb_r  <= rnd_q16(64'(nsq_r) * 64'(omb2));
    va6_r <= va_r;
    f6_r  <= f5_r;
    w16_r <= w15_r;

    // S7: bias-corrected moment divisions
    div2a_init_r <= (bc1 == '0) ? div_init(64'd0, 33'd1) : div_init({m6_r.mag, 32'b0}, bc1);
    div2b_init_r <= (bc2 == '0) ? div_init(64'd0, 33'd1) : div_init({v_s7, 32'b0}, bc2);
    s7_side_r.f  <= f6_r;
    s7_side_r.m  <= m6_r;
    s7_side_r.v  <= v_s7;
    s7_side_r.w1 <= w16_r;

    side2_r[0] <= s7_side_r;
    for (int k = 1; k < DIV_STEPS; k++) side2_r[k] <= side2_r[k-1];

    // S8
    sqrt_init_r.rem  <= '0;
    sqrt_init_r.xl   <= {vh_s8, 16'b0};
    sqrt_init_r.root <= '0;
    s8_side_r.f  <= side2_r[DIV_STEPS-1].f;
    s8_side_r.m  <= side2_r[DIV_STEPS-1].m;
    s8_side_r.v  <= side2_r[DIV_STEPS-1].v;
    s8_side_r.w1 <= side2_r[DIV_STEPS-1].w1;
    s8_side_r.mh <= mh_s8;

    side3_r[0] <= s8_side_r;
    for (int k = 1; k < SQRT_STEPS; k++) side3_r[k] <= side3_r[k-1];

    // S9
    x_r   <= rnd_q24(56'(lr_r) * 56'(side3_r[SQRT_STEPS-1].mh));
    den_r <= {1'b0, sq_q[SQRT_STEPS].root} + {9'b0, eps_r};
    s9_side_r.f  <= side3_r[SQRT_STEPS-1].f;
    s9_side_r.m  <= side3_r[SQRT_STEPS-1].m;
    s9_side_r.v  <= side3_r[SQRT_STEPS-1].v;
    s9_side_r.w1 <= side3_r[SQRT_STEPS-1].w1;

    // S10: Adam step division; zero denominator gives no step
    div3_init_r <= (den_r == '0) ? div_init(64'd0, 33'd1)
                                 : div_init({16'b0, x_r, 16'b0}, {8'b0, den_r});
    s10_side_r  <= s9_side_r;

    side4_r[0] <= s10_side_r;
    for (int k = 1; k < DIV_STEPS; k++) side4_r[k] <= side4_r[k-1];

    // S11
    upd_r      <= c3_q[DIV_STEPS].ovf ? UMAXV : c3_q[DIV_STEPS].quo;
    s11_side_r <= side4_r[DIV_STEPS-1];

    // S12
    wout_r <= to_bits(wn_s);
    fout_r <= s11_side_r.f;
    mout_r <= to_bits(s11_side_r.m);
    vout_r <= s11_side_r.v;
  end

  // ---- cell chains ----
  assign c1_q[0]  = div1_init_r;
  assign c2a_q[0] = div2a_init_r;
  assign c2b_q[0] = div2b_init_r;
  assign c3_q[0]  = div3_init_r;
  assign sq_q[0]  = sqrt_init_r;

  assign p1_q[0].p    = ONE_Q32;
  assign p1_q[0].base = {1'b0, b1_r, 16'b0};
  assign p1_q[0].t    = side1_r[POW_TAP].t;
  assign p2_q[0].p    = ONE_Q32;
  assign p2_q[0].base = {1'b0, b2_r, 16'b0};
  assign p2_q[0].t    = side1_r[POW_TAP].t;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    nga_div_cell u_c1  (.clk(clk), .cell_in(c1_q[k]),  .cell_out(c1_q[k+1]));
    nga_div_cell u_c2a (.clk(clk), .cell_in(c2a_q[k]), .cell_out(c2a_q[k+1]));
    nga_div_cell u_c2b (.clk(clk), .cell_in(c2b_q[k]), .cell_out(c2b_q[k+1]));
    nga_div_cell u_c3  (.clk(clk), .cell_in(c3_q[k]),  .cell_out(c3_q[k+1]));
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    nga_sqrt_cell u_sq (.clk(clk), .cell_in(sq_q[k]), .cell_out(sq_q[k+1]));
  end

  for (genvar k = 0; k < STEP_W; k++) begin : g_pow
    nga_pow_cell u_p1 (.clk(clk), .cell_in(p1_q[k]), .cell_out(p1_q[k+1]));
    nga_pow_cell u_p2 (.clk(clk), .cell_in(p2_q[k]), .cell_out(p2_q[k+1]));
  end

  assign out_valid             = vld_r[PIPE_DEPTH-1];
  assign out_weight_out        = $signed(wout_r);
  assign out_fisher_out        = fout_r;
  assign out_first_moment_out  = $signed(mout_r);
  assign out_second_moment_out = vout_r;

  // ---- checks ----
  a_n_sign: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_N] |-> !(n_r.neg && n_r.mag == '0))
    else $error("natural gradient carries a negative zero");

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_N] |-> n_r.mag <= SNEGV)
    else $error("natural gradient outside signed range");

  a_div2_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_M2] |-> (div2a_init_r.den != '0 && div2b_init_r.den != '0))
    else $error("moment correction divider fed a zero divisor");

  a_div3_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_DEN] |-> div3_init_r.den != '0)
    else $error("step divider fed a zero divisor");

endmodule
`default_nettype wire
